### rtl/core/dmft_pkg.sv
// Package for the lighting-bus master frame transceiver.
// Holds the shared types, mode codes, register indexes and reset values.
// No dependencies.
package dmft_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEND = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_RECV = 4'b1000
  } state_t;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;
  localparam logic [1:0] MODE_RECV = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [1:0] ADDR_SHORT        = 2'd0;
  localparam logic [1:0] ADDR_GROUP        = 2'd1;
  localparam logic [1:0] ADDR_BCAST        = 2'd2;
  localparam logic [1:0] ADDR_BCAST_DIRECT = 2'd3;

  localparam logic [1:0] CFG_DTR0    = 2'd0;
  localparam logic [1:0] CFG_DTR1    = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam logic [7:0] DTR0_RESET    = 8'd163;
  localparam logic [7:0] DTR1_RESET    = 8'd195;
  localparam logic [7:0] LIMIT_RESET   = 8'd63;
  localparam logic [7:0] TIMEOUT_RESET = 8'd200;

  localparam logic [7:0] BCAST_BYTE        = 8'hFF;
  localparam logic [7:0] BCAST_DIRECT_BYTE = 8'hFE;
  localparam logic [7:0] GROUP_FLAG        = 8'h80;
  localparam logic [7:0] REPLY_CMD_MIN     = 8'h90;

  localparam int REPLY_BITS   = 9;
  localparam int SAMPLE_IDX_W = 4;
  localparam int WAIT_W       = 9;
  localparam int SAMPLE_PHASE = 2;

  typedef struct packed {
    logic       op;
    logic       rx_level;
    logic [1:0] address_type;
    logic [7:0] address;
    logic [7:0] command;
    logic       direct_arc;
  } item_t;

  typedef struct packed {
    logic       tx_level;
    logic [1:0] mode;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       no_reply;
  } result_t;

  typedef struct packed {
    logic [7:0] dtr0_code;
    logic [7:0] dtr1_code;
    logic [7:0] address_limit;
    logic [7:0] reply_timeout_ticks;
  } cfg_t;

endpackage

### rtl/core/dmft_if.sv
// Channel interfaces of the lighting-bus master frame transceiver.
// One interface for the item channel and one for the result channel.
// No dependencies.
interface dmft_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       rx_level;
  logic [1:0] address_type;
  logic [7:0] address;
  logic [7:0] command;
  logic       direct_arc;

  modport source (output valid, op, rx_level, address_type, address, command, direct_arc,
                  input ready);
  modport sink (input valid, op, rx_level, address_type, address, command, direct_arc,
                output ready);
endinterface

interface dmft_out_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic [1:0] mode;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       no_reply;

  modport source (output valid, tx_level, mode, reply_valid, reply_byte, no_reply,
                  input ready);
  modport sink (input valid, tx_level, mode, reply_valid, reply_byte, no_reply,
                output ready);
endinterface

### rtl/core/dmft_frame_enc.sv
// Forward frame encoder: address byte, frame bit order and reply expectation.
// Depends on dmft_pkg.
module dmft_frame_enc
  import dmft_pkg::*;
#(
  parameter int FORWARD_BITS = 17
) (
  input  item_t                   item,
  input  cfg_t                    cfg,
  output logic [FORWARD_BITS-1:0] frame,
  output logic                    expect_reply
);

  logic [7:0] addr_byte;

  always_comb begin
    addr_byte = item.address;
    case (item.address_type)
      ADDR_BCAST: begin
        addr_byte = BCAST_BYTE;
      end
      ADDR_BCAST_DIRECT: begin
        addr_byte = BCAST_DIRECT_BYTE;
      end
      default: begin
        if (item.address <= cfg.address_limit) begin
          addr_byte = {item.address[6:0], item.direct_arc};
          if (item.address_type == ADDR_GROUP) begin
            addr_byte = addr_byte | GROUP_FLAG;
          end
        end
      end
    endcase
  end

  // Start bit first, then both bytes MSB first; spare positions stay low.
  always_comb begin
    frame    = '0;
    frame[0] = 1'b1;
    for (int i = 0; i < 8; i++) begin
      frame[1 + i] = addr_byte[7 - i];
      frame[9 + i] = item.command[7 - i];
    end
  end

  assign expect_reply = (item.command >= REPLY_CMD_MIN) && (addr_byte != cfg.dtr0_code) &&
                        (addr_byte != cfg.dtr1_code);

endmodule

### rtl/core/dmft_line_ctrl.sv
// Bus line controller: Manchester transmit, reply wait and reply sampling.
// Depends on dmft_pkg; the frame comes from dmft_frame_enc.
module dmft_line_ctrl
  import dmft_pkg::*;
#(
  parameter int TICKS_PER_BIT = 8,
  parameter int FORWARD_BITS  = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  item_t                   item,
  input  cfg_t                    cfg,
  input  logic [FORWARD_BITS-1:0] frame_in,
  input  logic                    expect_in,
  output result_t                 result
);

  localparam int PH_W  = $clog2(TICKS_PER_BIT);
  localparam int BIT_W = $clog2(FORWARD_BITS + 1);
  localparam int IDX_W = $clog2(FORWARD_BITS);
  localparam logic [PH_W-1:0] PH_HALF   = PH_W'(TICKS_PER_BIT / 2);
  localparam logic [PH_W-1:0] PH_LAST   = PH_W'(TICKS_PER_BIT - 1);
  localparam logic [PH_W-1:0] PH_SAMPLE = PH_W'(SAMPLE_PHASE);

  state_t                  state, state_next;
  logic [PH_W-1:0]         phase, phase_next;
  logic [BIT_W-1:0]        bit_cnt, bit_cnt_next;
  logic [WAIT_W-1:0]       wait_cnt, wait_cnt_next;
  logic [FORWARD_BITS-1:0] frame_bits, frame_bits_next;
  logic [REPLY_BITS-1:0]   sample_bits, sample_bits_next;
  logic                    expect_reply, expect_reply_next;
  logic                    line_drive, line_drive_next;
  logic                    reply_valid;
  logic [7:0]              reply_byte;
  logic                    no_reply;
  logic                    cur_bit;
  logic [BIT_W-1:0]        bit_inc;
  logic [1:0]              mode_code;

  assign cur_bit = frame_bits[bit_cnt[IDX_W-1:0]];
  assign bit_inc = bit_cnt + BIT_W'(1);

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    bit_cnt_next      = bit_cnt;
    wait_cnt_next     = wait_cnt;
    frame_bits_next   = frame_bits;
    sample_bits_next  = sample_bits;
    expect_reply_next = expect_reply;
    line_drive_next   = line_drive;
    reply_valid       = 1'b0;
    reply_byte        = '0;
    no_reply          = 1'b0;
    if (item.op == OP_SEND) begin
      frame_bits_next   = frame_in;
      expect_reply_next = expect_in;
      line_drive_next   = 1'b0;
      state_next        = ST_SEND;
      phase_next        = '0;
      bit_cnt_next      = '0;
    end else begin
      case (state)
        ST_SEND: begin
          if (phase == '0) begin
            line_drive_next = cur_bit;
          end else if (phase == PH_HALF) begin
            line_drive_next = ~cur_bit;
          end
          if (phase == PH_LAST) begin
            phase_next   = '0;
            bit_cnt_next = bit_inc;
            if (bit_inc == BIT_W'(FORWARD_BITS)) begin
              line_drive_next = 1'b0;
              bit_cnt_next    = '0;
              wait_cnt_next   = '0;
              state_next      = expect_reply ? ST_WAIT : ST_IDLE;
            end
          end else begin
            phase_next = phase + PH_W'(1);
          end
        end
        ST_WAIT: begin
          if (wait_cnt > {1'b0, cfg.reply_timeout_ticks}) begin
            sample_bits_next = '0;
            no_reply         = 1'b1;
            state_next       = ST_IDLE;
            wait_cnt_next    = '0;
            phase_next       = '0;
            bit_cnt_next     = '0;
          end else if (item.rx_level) begin
            state_next   = ST_RECV;
            phase_next   = PH_W'(1);
            bit_cnt_next = '0;
          end else begin
            wait_cnt_next = wait_cnt + WAIT_W'(1);
          end
        end
        ST_RECV: begin
          if (phase == PH_SAMPLE) begin
            sample_bits_next[bit_cnt[SAMPLE_IDX_W-1:0]] = item.rx_level;
          end
          phase_next = (phase == PH_LAST) ? '0 : phase + PH_W'(1);
          if (phase_next == PH_LAST) begin
            bit_cnt_next = bit_inc;
          end
          if (bit_cnt_next == BIT_W'(REPLY_BITS)) begin
            for (int i = 0; i < 8; i++) begin
              reply_byte[7 - i] = sample_bits_next[i + 1];
            end
            reply_valid       = 1'b1;
            expect_reply_next = 1'b0;
            state_next        = ST_IDLE;
            phase_next        = '0;
            bit_cnt_next      = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (state_next)
      ST_SEND: mode_code = MODE_SEND;
      ST_WAIT: mode_code = MODE_WAIT;
      ST_RECV: mode_code = MODE_RECV;
      default: mode_code = MODE_IDLE;
    endcase
  end

  assign result = '{tx_level: line_drive_next, mode: mode_code, reply_valid: reply_valid,
                    reply_byte: reply_byte, no_reply: no_reply};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= '0;
      bit_cnt      <= '0;
      wait_cnt     <= '0;
      frame_bits   <= '0;
      sample_bits  <= '0;
      expect_reply <= 1'b0;
      line_drive   <= 1'b0;
    end else if (step) begin
      state        <= state_next;
      phase        <= phase_next;
      bit_cnt      <= bit_cnt_next;
      wait_cnt     <= wait_cnt_next;
      frame_bits   <= frame_bits_next;
      sample_bits  <= sample_bits_next;
      expect_reply <= expect_reply_next;
      line_drive   <= line_drive_next;
    end
  end

endmodule

### rtl/core/dali_master_frame_transceiver_top.sv
// Lighting-bus master frame transceiver. Every transaction on the item channel is either a
// timer tick (TICKS_PER_BIT ticks make one bus bit) or a request to send a forward frame,
// and yields exactly one result transaction with the transmit drive, the bus mode and any
// completed reply or reply timeout. A transaction is taken in every cycle unless the result
// side stalls; it passes the input register and then the result register, and either side
// may stall without losing a transaction. The user must write configuration registers
// through the plain write port only while no transaction is in flight; the block does not
// enforce it. Depends on dmft_pkg, dmft_if, dmft_frame_enc and dmft_line_ctrl.
module dali_master_frame_transceiver_top
  import dmft_pkg::*;
#(
  parameter int TICKS_PER_BIT = 8,
  parameter int FORWARD_BITS  = 17
) (
  input  logic       clk,
  input  logic       rst,
  dmft_in_if.sink    in_ch,
  dmft_out_if.source out_ch,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t                    cfg;
  item_t                   item_q;
  logic                    item_valid;
  result_t                 result;
  result_t                 result_q;
  logic                    result_valid;
  logic                    advance;
  logic [FORWARD_BITS-1:0] frame;
  logic                    expect_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dtr0_code           <= DTR0_RESET;
      cfg.dtr1_code           <= DTR1_RESET;
      cfg.address_limit       <= LIMIT_RESET;
      cfg.reply_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DTR0:    cfg.dtr0_code           <= cfg_data;
        CFG_DTR1:    cfg.dtr1_code           <= cfg_data;
        CFG_LIMIT:   cfg.address_limit       <= cfg_data;
        CFG_TIMEOUT: cfg.reply_timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance     = item_valid && (!result_valid || out_ch.ready);
  assign in_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q <= '{op: in_ch.op, rx_level: in_ch.rx_level, address_type: in_ch.address_type,
                  address: in_ch.address, command: in_ch.command,
                  direct_arc: in_ch.direct_arc};
    end
  end

  dmft_frame_enc #(
    .FORWARD_BITS(FORWARD_BITS)
  ) u_frame_enc (
    .item        (item_q),
    .cfg         (cfg),
    .frame       (frame),
    .expect_reply(expect_reply)
  );

  dmft_line_ctrl #(
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .FORWARD_BITS (FORWARD_BITS)
  ) u_line_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (item_q),
    .cfg      (cfg),
    .frame_in (frame),
    .expect_in(expect_reply),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (out_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_ch.valid       = result_valid;
  assign out_ch.tx_level    = result_q.tx_level;
  assign out_ch.mode        = result_q.mode;
  assign out_ch.reply_valid = result_q.reply_valid;
  assign out_ch.reply_byte  = result_q.reply_byte;
  assign out_ch.no_reply    = result_q.no_reply;

endmodule

### verif/testbench.sv
// Self-checking testbench for the lighting-bus master frame transceiver top level.
// Drives random and directed ticks and frame requests through a behavioural model of the bus
// master and checks every result. Depends on dmft_pkg, dmft_if and the RTL top level.
module testbench
  import dmft_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICKS_PER_BIT = 8;
  localparam int FORWARD_BITS  = 17;
  localparam int FRAME_TICKS   = TICKS_PER_BIT * FORWARD_BITS;
  localparam int PHASE_ITEMS   = 25;
  localparam int ITEM_W        = $bits(item_t);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  dmft_in_if  in_ch ();
  dmft_out_if out_ch ();

  dali_master_frame_transceiver_top #(
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .FORWARD_BITS (FORWARD_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural copy of the bus master.
  cfg_t                    regs;
  logic [1:0]              bus_state;
  logic [8:0]              bit_phase;
  logic [4:0]              bit_index;
  logic [FORWARD_BITS-1:0] fwd_frame;
  logic [8:0]              rx_bits;
  logic                    reply_due;
  logic                    tx_drive;

  item_t   bus_items [$];
  result_t awaited_results [$];
  int      items_queued = 0;
  int      items_taken = 0;
  int      items_sent = 0;
  int      err_count = 0;
  int      calm [2] = '{0, 0};
  int      send_gap = 0;
  int      hold_left = 0;
  item_t   nxt;
  item_t   seen;
  result_t want;

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] address_byte(item_t it);
    logic [7:0] abyte;
    abyte = it.address;
    if (it.address_type == ADDR_BCAST) begin
      abyte = BCAST_BYTE;
    end else if (it.address_type == ADDR_BCAST_DIRECT) begin
      abyte = BCAST_DIRECT_BYTE;
    end else if (it.address <= regs.address_limit) begin
      abyte = {it.address[6:0], it.direct_arc};
      if (it.address_type == ADDR_GROUP) begin
        abyte = abyte | GROUP_FLAG;
      end
    end
    return abyte;
  endfunction

  function automatic result_t predict_bus_result(item_t it);
    result_t    r;
    logic [7:0] abyte;
    int         pos;
    logic       b;
    r = '0;
    if (it.op == OP_SEND) begin
      abyte = address_byte(it);
      fwd_frame = '0;
      fwd_frame[0] = 1'b1;
      for (int i = 0; i < 8; i++) begin
        fwd_frame[1 + i] = abyte[7 - i];
        fwd_frame[9 + i] = it.command[7 - i];
      end
      reply_due = (it.command >= REPLY_CMD_MIN) && (abyte != regs.dtr0_code) &&
                  (abyte != regs.dtr1_code);
      tx_drive = 1'b0;
      bus_state = MODE_SEND;
      bit_phase = '0;
      bit_index = '0;
    end else if (bus_state == MODE_SEND) begin
      pos = int'(bit_phase) % TICKS_PER_BIT;
      if (bit_index < FORWARD_BITS) begin
        b = fwd_frame[bit_index];
        if (pos == 0) begin
          tx_drive = b;
        end else if (pos == TICKS_PER_BIT / 2) begin
          tx_drive = ~b;
        end
      end
      bit_phase = bit_phase + 9'd1;
      if (int'(bit_phase) % TICKS_PER_BIT == 0) begin
        bit_index = bit_index + 5'd1;
      end
      if (bit_index >= FORWARD_BITS) begin
        tx_drive = 1'b0;
        bit_phase = '0;
        bit_index = '0;
        bus_state = reply_due ? MODE_WAIT : MODE_IDLE;
      end
    end else if (bus_state == MODE_WAIT) begin
      if (bit_phase > regs.reply_timeout_ticks) begin
        rx_bits = '0;
        r.no_reply = 1'b1;
        bus_state = MODE_IDLE;
        bit_phase = '0;
        bit_index = '0;
      end else begin
        if (it.rx_level) begin
          bus_state = MODE_RECV;
          bit_phase = '0;
          bit_index = '0;
        end
        bit_phase = bit_phase + 9'd1;
      end
    end else if (bus_state == MODE_RECV) begin
      if (bit_index <= 8 &&
          int'(bit_phase) == int'(bit_index) * TICKS_PER_BIT + SAMPLE_PHASE) begin
        rx_bits[bit_index] = it.rx_level;
      end
      bit_phase = bit_phase + 9'd1;
      if ((int'(bit_phase) + 1) % TICKS_PER_BIT == 0) begin
        bit_index = bit_index + 5'd1;
      end
      if (bit_index > 8) begin
        for (int i = 0; i < 8; i++) begin
          r.reply_byte[7 - i] = rx_bits[i + 1];
        end
        r.reply_valid = 1'b1;
        reply_due = 1'b0;
        bus_state = MODE_IDLE;
        bit_phase = '0;
        bit_index = '0;
      end
    end
    r.tx_level = tx_drive;
    r.mode = bus_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    err_count++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  function automatic int pick_gap(input int side);
    int r;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm[side] = $urandom_range(20, 120);
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A transaction is accepted on the item channel and its result predicted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.op = in_ch.op;
        seen.rx_level = in_ch.rx_level;
        seen.address_type = in_ch.address_type;
        seen.address = in_ch.address;
        seen.command = in_ch.command;
        seen.direct_arc = in_ch.direct_arc;
        awaited_results.push_back(predict_bus_result(seen));
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", int'(out_ch.mode), 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.tx_level !== want.tx_level)
            report_mismatch("tx_level", int'(out_ch.tx_level), int'(want.tx_level));
          if (out_ch.mode !== want.mode)
            report_mismatch("mode", int'(out_ch.mode), int'(want.mode));
          if (out_ch.reply_valid !== want.reply_valid)
            report_mismatch("reply_valid", int'(out_ch.reply_valid), int'(want.reply_valid));
          if (out_ch.reply_byte !== want.reply_byte)
            report_mismatch("reply_byte", int'(out_ch.reply_byte), int'(want.reply_byte));
          if (out_ch.no_reply !== want.no_reply)
            report_mismatch("no_reply", int'(out_ch.no_reply), int'(want.no_reply));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_TICK;
      in_ch.rx_level <= 1'b0;
      in_ch.address_type <= ADDR_SHORT;
      in_ch.address <= '0;
      in_ch.command <= '0;
      in_ch.direct_arc <= 1'b0;
    end else if (items_taken == items_sent) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        nxt = bus_items.pop_front();
        in_ch.op <= nxt.op;
        in_ch.rx_level <= nxt.rx_level;
        in_ch.address_type <= nxt.address_type;
        in_ch.address <= nxt.address;
        in_ch.command <= nxt.command;
        in_ch.direct_arc <= nxt.direct_arc;
        in_ch.valid <= 1'b1;
        items_sent++;
        send_gap = pick_gap(0);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        hold_left = pick_gap(1);
      end
    end
  end

  task automatic push_raw();
    bus_items.push_back(item_t'(ITEM_W'($urandom)));
    items_queued++;
  endtask

  task automatic push_tick(input logic rx);
    item_t it;
    it = item_t'(ITEM_W'($urandom));
    it.op = OP_TICK;
    it.rx_level = rx;
    bus_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_send(input logic [1:0] kind, input logic [7:0] addr,
                           input logic [7:0] cmd, input logic arc);
    item_t it;
    it.op = OP_SEND;
    it.rx_level = coin();
    it.address_type = kind;
    it.address = addr;
    it.command = cmd;
    it.direct_arc = arc;
    bus_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_random_send();
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] cmd;
    kind = 2'($urandom_range(0, 3));
    addr = coin() ? 8'($urandom_range(0, regs.address_limit)) : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      kind = ADDR_SHORT;
      addr = coin() ? regs.dtr0_code : regs.dtr1_code;
    end
    cmd = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(REPLY_CMD_MIN, 255)) :
                                        8'($urandom_range(0, 255));
    push_send(kind, addr, cmd, coin());
  endtask

  task automatic run_frame();
    repeat (FRAME_TICKS) push_tick(coin());
  endtask

  task automatic await_timeout();
    repeat (int'(regs.reply_timeout_ticks) + 2) push_tick(1'b0);
  endtask

  // Backward frame: a quiet lead-in, the rising edge, then nine bits held at each sample.
  task automatic answer(input int lead, input logic [8:0] pattern);
    int t;
    int k;
    repeat (lead) push_tick(1'b0);
    push_tick(1'b1);
    for (t = 1; t <= 9 * TICKS_PER_BIT - 2; t++) begin
      k = (t + 1) / TICKS_PER_BIT;
      if (t != k * TICKS_PER_BIT + SAMPLE_PHASE && $urandom_range(0, 3) == 0) begin
        push_tick(coin());
      end else begin
        push_tick(pattern[k]);
      end
    end
  endtask

  task automatic random_phase(input int count);
    int stop;
    int pick;
    stop = items_queued + count;
    while (items_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        push_random_send();
      end
      if (pick < 55) begin
        run_frame();
        answer($urandom_range(0, regs.reply_timeout_ticks), 9'($urandom));
      end else if (pick < 70) begin
        run_frame();
        await_timeout();
      end else if (pick < 85) begin
        repeat ($urandom_range(0, 220)) push_tick(coin());
      end else begin
        repeat ($urandom_range(1, 8)) push_raw();
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    while (bus_state != MODE_IDLE) begin
      repeat (2 * TICKS_PER_BIT) push_tick(1'b0);
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DTR0: regs.dtr0_code = val;
      CFG_DTR1: regs.dtr1_code = val;
      CFG_LIMIT: regs.address_limit = val;
      default: regs.reply_timeout_ticks = val;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] dtr0, input logic [7:0] dtr1,
                          input logic [7:0] limit, input logic [7:0] wait_ticks);
    write_reg(CFG_DTR0, dtr0);
    write_reg(CFG_DTR1, dtr1);
    write_reg(CFG_LIMIT, limit);
    write_reg(CFG_TIMEOUT, wait_ticks);
  endtask

  initial begin
    cfg_write = 1'b0;
    cfg_index = CFG_DTR0;
    cfg_data = '0;
    regs.dtr0_code = DTR0_RESET;
    regs.dtr1_code = DTR1_RESET;
    regs.address_limit = LIMIT_RESET;
    regs.reply_timeout_ticks = TIMEOUT_RESET;
    bus_state = MODE_IDLE;
    bit_phase = '0;
    bit_index = '0;
    fwd_frame = '0;
    rx_bits = '0;
    reply_due = 1'b0;
    tx_drive = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_tick(1'b1);
    push_tick(1'b0);
    push_send(ADDR_SHORT, 8'h00, 8'h00, 1'b0);
    repeat (3) push_tick(coin());
    push_send(ADDR_GROUP, LIMIT_RESET, 8'hFF, 1'b1);
    repeat (12) push_tick(coin());
    push_send(ADDR_BCAST, 8'hFF, 8'h8F, 1'b1);
    repeat (5) push_tick(coin());
    push_send(ADDR_BCAST_DIRECT, 8'h00, REPLY_CMD_MIN, 1'b0);
    repeat (20) push_tick(coin());
    push_send(ADDR_SHORT, LIMIT_RESET + 8'd1, REPLY_CMD_MIN, 1'b1);
    run_frame();
    answer(0, 9'h1FF);
    settle();
    random_phase(PHASE_ITEMS);
    settle();

    set_regs(8'h00, 8'hFF, 8'h00, 8'd1);
    push_send(ADDR_SHORT, 8'h2A, 8'hAA, 1'b0);
    run_frame();
    await_timeout();
    random_phase(PHASE_ITEMS);
    settle();

    set_regs(8'hFF, 8'h00, 8'hFF, 8'd255);
    random_phase(PHASE_ITEMS);
    settle();

    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)));
    random_phase(PHASE_ITEMS);
    settle();

    repeat (10) @(negedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
